### hdl/rsp_pkg.sv
// Shared types and constants for the rectangle subtract pieces unit.
`timescale 1ns / 1ps

package rsp_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_UNTOUCHED = 2'd0,
        ST_ERASED    = 2'd1,
        ST_PIECE     = 2'd2
    } rsp_status_t;

    // Up to four remainder pieces per item
    localparam int NUM_PIECES = 4;

    // Edge slots inside one packed piece
    localparam int EDGE_L = 0;
    localparam int EDGE_R = 1;
    localparam int EDGE_B = 2;
    localparam int EDGE_T = 3;

    // Job queue between the classifier and the emitter
    localparam int QUEUE_DEPTH = 2;

    // Job header: what the emitter walks through
    typedef struct packed {
        rsp_status_t             status;
        logic [NUM_PIECES-1:0]   mask;
    } rsp_head_t;

endpackage

### hdl/rsp_front.sv
// Classifier: overlap, eraser class and candidate remainder pieces for one item.
`timescale 1ns / 1ps

module rsp_front #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]                          target_left,
    input  logic signed [COORD_BITS-1:0]                          target_right,
    input  logic signed [COORD_BITS-1:0]                          target_bottom,
    input  logic signed [COORD_BITS-1:0]                          target_top,
    input  logic signed [COORD_BITS-1:0]                          eraser_left,
    input  logic signed [COORD_BITS-1:0]                          eraser_right,
    input  logic signed [COORD_BITS-1:0]                          eraser_bottom,
    input  logic signed [COORD_BITS-1:0]                          eraser_top,
    output rsp_pkg::rsp_head_t                                    head,
    output logic [rsp_pkg::NUM_PIECES-1:0][3:0][COORD_BITS-1:0]   pieces
);
    import rsp_pkg::*;

    typedef enum logic [2:0] {
        CLS_LEFT,
        CLS_RIGHT,
        CLS_BOTTOM,
        CLS_TOP,
        CLS_INSIDE
    } cls_t;

    typedef logic [3:0][COORD_BITS-1:0] piece_t;

    logic signed [COORD_BITS-1:0] ov_l, ov_r, ov_b, ov_t;
    logic                         ov_empty, ov_whole;
    cls_t                         cls;
    piece_t [NUM_PIECES-1:0]      cand;
    logic   [NUM_PIECES-1:0]      pre;
    logic   [NUM_PIECES-1:0]      keep;

    function automatic piece_t mk(
        input logic [COORD_BITS-1:0] l,
        input logic [COORD_BITS-1:0] r,
        input logic [COORD_BITS-1:0] b,
        input logic [COORD_BITS-1:0] t
    );
        piece_t p;
        p         = '0;
        p[EDGE_L] = l;
        p[EDGE_R] = r;
        p[EDGE_B] = b;
        p[EDGE_T] = t;
        return p;
    endfunction

    // plain max/min overlap
    assign ov_l = (target_left   > eraser_left)   ? target_left   : eraser_left;
    assign ov_r = (target_right  < eraser_right)  ? target_right  : eraser_right;
    assign ov_b = (target_bottom > eraser_bottom) ? target_bottom : eraser_bottom;
    assign ov_t = (target_top    < eraser_top)    ? target_top    : eraser_top;

    assign ov_empty = (ov_r <= ov_l) || (ov_t <= ov_b);
    assign ov_whole = (ov_l == target_left) && (ov_r == target_right)
                   && (ov_b == target_bottom) && (ov_t == target_top);

    always_comb
    begin
        if (eraser_left <= target_left && eraser_right > target_left)
            cls = CLS_LEFT;
        else if (eraser_right >= target_right && eraser_left < target_right)
            cls = CLS_RIGHT;
        else if (eraser_bottom <= target_bottom && eraser_top > target_bottom)
            cls = CLS_BOTTOM;
        else if (eraser_top >= target_top && eraser_bottom < target_top)
            cls = CLS_TOP;
        else
            cls = CLS_INSIDE;
    end

    // candidate pieces in emission order
    always_comb
    begin
        cand = '0;
        pre  = '0;
        case (cls)
            CLS_LEFT:
            begin
                cand[0] = mk(ov_r, target_right, target_bottom, target_top);
                cand[1] = mk(target_left, ov_r, ov_t, target_top);
                cand[2] = mk(target_left, ov_r, target_bottom, ov_b);
                pre     = {1'b0, target_bottom < eraser_bottom,
                           target_top > eraser_top, target_right > eraser_right};
            end
            CLS_RIGHT:
            begin
                cand[0] = mk(target_left, ov_l, target_bottom, target_top);
                cand[1] = mk(ov_l, target_right, ov_t, target_top);
                cand[2] = mk(ov_l, target_right, target_bottom, ov_b);
                pre     = {1'b0, target_bottom < eraser_bottom,
                           target_top > eraser_top, target_left < eraser_left};
            end
            CLS_BOTTOM:
            begin
                cand[0] = mk(target_left, target_right, ov_t, target_top);
                cand[1] = mk(target_left, ov_l, target_bottom, ov_t);
                cand[2] = mk(ov_r, target_right, target_bottom, ov_t);
                pre     = {1'b0, target_right > eraser_right,
                           target_left < eraser_left, target_top > eraser_top};
            end
            CLS_TOP:
            begin
                cand[0] = mk(target_left, target_right, target_bottom, ov_b);
                cand[1] = mk(target_left, ov_l, ov_b, target_top);
                cand[2] = mk(ov_r, target_right, ov_b, target_top);
                pre     = {1'b0, target_right > eraser_right,
                           target_left < eraser_left, target_bottom < eraser_bottom};
            end
            default:
            begin
                cand[0] = mk(target_left, eraser_left, target_bottom, target_top);
                cand[1] = mk(eraser_right, target_right, target_bottom, target_top);
                cand[2] = mk(eraser_left, eraser_right, eraser_top, target_top);
                cand[3] = mk(eraser_left, eraser_right, target_bottom, eraser_bottom);
                pre     = '1;
            end
        endcase
    end

    // a piece is kept only with positive width and height
    always_comb
    begin
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            keep[i] = pre[i]
                   && ($signed(cand[i][EDGE_R]) > $signed(cand[i][EDGE_L]))
                   && ($signed(cand[i][EDGE_T]) > $signed(cand[i][EDGE_B]));
        end
    end

    always_comb
    begin
        if (ov_empty)
        begin
            head.status = ST_UNTOUCHED;
            head.mask   = NUM_PIECES'(1);
            pieces      = '0;
        end
        else if (ov_whole || keep == '0)
        begin
            head.status = ST_ERASED;
            head.mask   = NUM_PIECES'(1);
            pieces      = '0;
        end
        else
        begin
            head.status = ST_PIECE;
            head.mask   = keep;
            pieces      = cand;
        end
    end

endmodule

### hdl/rsp_queue.sv
// Short job queue between classifier and emitter.
`timescale 1ns / 1ps

module rsp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### hdl/rsp_back.sv
// Emitter: walks a job's piece mask and drives one result beat per cycle while its output register is free.
`timescale 1ns / 1ps

module rsp_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  rsp_pkg::rsp_head_t                                    job_head,
    input  logic [rsp_pkg::NUM_PIECES-1:0][3:0][COORD_BITS-1:0]   job_pieces,
    input  logic                                                  job_empty,
    output logic                                                  job_pop,
    output logic                                                  empty,
    input  logic                                                  pop,
    output logic [1:0]                                            status,
    output logic signed [COORD_BITS-1:0]                          piece_left,
    output logic signed [COORD_BITS-1:0]                          piece_right,
    output logic signed [COORD_BITS-1:0]                          piece_bottom,
    output logic signed [COORD_BITS-1:0]                          piece_top,
    output logic                                                  last
);
    import rsp_pkg::*;

    localparam int SEL_W = $clog2(NUM_PIECES);

    rsp_head_t                                   cur_reg, cur_next;
    logic [NUM_PIECES-1:0][3:0][COORD_BITS-1:0]  cur_pieces_reg;
    logic                                        out_valid_reg;
    rsp_status_t                                 out_status_reg;
    logic [3:0][COORD_BITS-1:0]                  out_piece_reg;
    logic                                        out_last_reg;

    logic [SEL_W-1:0]      sel;
    logic [NUM_PIECES-1:0] rem;
    logic                  out_free, emit, job_done;

    // lowest pending piece
    always_comb
    begin
        sel = '0;
        for (int i = NUM_PIECES - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
                sel = SEL_W'(i);
        end
    end

    assign rem      = cur_reg.mask & ~(NUM_PIECES'(1) << sel);
    assign out_free = !out_valid_reg || pop;
    assign emit     = out_free && (cur_reg.mask != '0);
    assign job_done = (cur_reg.mask == '0) || (emit && rem == '0);
    assign job_pop  = job_done && !job_empty;

    always_comb
    begin
        cur_next = cur_reg;
        if (job_pop)
            cur_next = job_head;
        else if (emit)
            cur_next.mask = rem;
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            cur_pieces_reg <= job_pieces;
        if (emit)
        begin
            out_status_reg <= cur_reg.status;
            out_piece_reg  <= cur_pieces_reg[sel];
            out_last_reg   <= (rem == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '{status: ST_UNTOUCHED, mask: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty        = !out_valid_reg;
    assign status       = out_status_reg;
    assign piece_left   = out_piece_reg[EDGE_L];
    assign piece_right  = out_piece_reg[EDGE_R];
    assign piece_bottom = out_piece_reg[EDGE_B];
    assign piece_top    = out_piece_reg[EDGE_T];
    assign last         = out_last_reg;

endmodule

### hdl/rectangle_subtract_pieces_unit.sv
// Top level of the rectangle subtract pieces unit: classifier, job queue, emitter.
`timescale 1ns / 1ps

// Removes an axis-aligned eraser rectangle from a target rectangle (edges
// left/right/bottom/top, y up, two's complement) and returns the remainder.
// Each input beat produces one or more result beats; the final one of an
// item has last set. An empty overlap yields a single untouched beat, an
// overlap covering the whole target a single fully-erased beat (both with
// zeroed piece fields); otherwise one piece beat per non-empty remainder
// piece, up to four, in a fixed order per eraser class (left, right,
// bottom, top, inside). The classifier works on the input beat in the
// cycle it is pushed and drops a job into a two-entry queue; the emitter
// sends one result beat per cycle from its output register while the
// receiver pops or the register is empty; an item holds the emitter until
// its last beat is sent, and single-beat items stream at one per cycle
// under that condition. On an idle unit the first result beat goes through
// the queue, the emitter's job register and the output register. full rises
// only when the job queue holds two jobs the emitter has not reached yet;
// empty is the inverse of the output register's valid.
module rectangle_subtract_pieces_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_BITS-1:0]  target_left,
    input  logic signed [COORD_BITS-1:0]  target_right,
    input  logic signed [COORD_BITS-1:0]  target_bottom,
    input  logic signed [COORD_BITS-1:0]  target_top,
    input  logic signed [COORD_BITS-1:0]  eraser_left,
    input  logic signed [COORD_BITS-1:0]  eraser_right,
    input  logic signed [COORD_BITS-1:0]  eraser_bottom,
    input  logic signed [COORD_BITS-1:0]  eraser_top,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    status,
    output logic signed [COORD_BITS-1:0]  piece_left,
    output logic signed [COORD_BITS-1:0]  piece_right,
    output logic signed [COORD_BITS-1:0]  piece_bottom,
    output logic signed [COORD_BITS-1:0]  piece_top,
    output logic                          last
);
    import rsp_pkg::*;

    localparam int PIECES_W = NUM_PIECES * 4 * COORD_BITS;
    localparam int JOB_W    = $bits(rsp_head_t) + PIECES_W;

    rsp_head_t                                   fr_head, q_head;
    logic [NUM_PIECES-1:0][3:0][COORD_BITS-1:0]  fr_pieces, q_pieces;
    logic [JOB_W-1:0]                            q_rd_data;
    logic                                        q_empty, q_pop;

    // classify the incoming beat
    rsp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .target_left   (target_left),
        .target_right  (target_right),
        .target_bottom (target_bottom),
        .target_top    (target_top),
        .eraser_left   (eraser_left),
        .eraser_right  (eraser_right),
        .eraser_bottom (eraser_bottom),
        .eraser_top    (eraser_top),
        .head          (fr_head),
        .pieces        (fr_pieces)
    );

    // decouples classifier from emitter
    rsp_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({fr_head, fr_pieces}),
        .full    (full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign q_head   = q_rd_data[JOB_W-1 -: $bits(rsp_head_t)];
    assign q_pieces = q_rd_data[PIECES_W-1:0];

    // one result beat per cycle while the output register is free
    rsp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_head     (q_head),
        .job_pieces   (q_pieces),
        .job_empty    (q_empty),
        .job_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .piece_left   (piece_left),
        .piece_right  (piece_right),
        .piece_bottom (piece_bottom),
        .piece_top    (piece_top),
        .last         (last)
    );

    // untouched and erased beats stand alone
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_PIECE) |-> last)
        else $error("non-piece result without last");

    // untouched and erased beats carry zero geometry
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_PIECE) |->
        (piece_left == '0 && piece_right == '0 && piece_bottom == '0 && piece_top == '0))
        else $error("non-piece result with nonzero fields");

    // every emitted piece has positive area
    a_piece_area: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_PIECE) |->
        (piece_right > piece_left && piece_top > piece_bottom))
        else $error("degenerate piece emitted");

    // status never carries the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_UNTOUCHED || status == ST_ERASED || status == ST_PIECE))
        else $error("bad status code");

endmodule

### dv/tb_rectangle_subtract_pieces_unit.sv
// Self-checking testbench for the rectangle subtract pieces unit.
`timescale 1ns / 1ps

// Flow: an initial block fills rect_q with rectangle pairs, directed cases
// first, then random ones. The driver pushes them one beat at a time with
// random gaps. On every accepted beat, subtract_rect() predicts the result
// beats and appends them to beat_q. The monitor pops with random gaps and
// checks each popped beat, field by field, against the head of beat_q.
// One long receiver hold-off fills the job queue so that full stalls the
// sender. A watchdog ends the run if no beat moves on either side for too long.
module tb_rectangle_subtract_pieces_unit;

    import rsp_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int N_RANDOM    = 390;
    localparam int IDLE_PCT    = 24;
    localparam int HOLD_CYCLES = 80;     // receiver hold-off for the pressure phase
    localparam int STALL_LIMIT = 2000;   // cycles without any beat moving
    localparam int TAIL_CYCLES = 20;     // drain time after the last expected beat
    localparam int MAX_SHOWN   = 10;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t tl, tr, tb, tt;   // target edges
        coord_t el, er, eb, et;   // eraser edges
    } rect_pair_t;

    typedef struct {
        rsp_status_t status;
        coord_t      l, r, b, t;
        logic        last;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic       hold = 1'b0;
    rect_pair_t offer = '{default: '0};

    logic       full;
    logic       empty;
    logic [1:0] status;
    coord_t     piece_left, piece_right, piece_bottom, piece_top;
    logic       last;

    rect_pair_t rect_q[$];     // pairs waiting to be pushed
    beat_t      beat_q[$];     // predicted result beats, oldest first
    beat_t      piece_buf[$];  // remainder pieces of the pair being predicted

    int n_items;
    int items_in = 0;
    int beats_out = 0;
    int n_err = 0;
    int n_untouched = 0;
    int n_erased = 0;
    int n_pieces = 0;
    int stall_cnt = 0;

    rectangle_subtract_pieces_unit #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .target_left  (offer.tl),
        .target_right (offer.tr),
        .target_bottom(offer.tb),
        .target_top   (offer.tt),
        .eraser_left  (offer.el),
        .eraser_right (offer.er),
        .eraser_bottom(offer.eb),
        .eraser_top   (offer.et),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .piece_left   (piece_left),
        .piece_right  (piece_right),
        .piece_bottom (piece_bottom),
        .piece_top    (piece_top),
        .last         (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_piece(coord_t l, coord_t r, coord_t b, coord_t t);
        beat_t pb;
        if (r > l && t > b && piece_buf.size() < NUM_PIECES)
        begin
            pb.status = ST_PIECE;
            pb.l = l;
            pb.r = r;
            pb.b = b;
            pb.t = t;
            pb.last = 1'b0;
            piece_buf.push_back(pb);
        end
    endfunction

    function automatic void subtract_rect(rect_pair_t p);
        coord_t      ol, orr, ob, ot;
        rsp_status_t lone;
        beat_t       bt;
        ol  = (p.tl > p.el) ? p.tl : p.el;
        orr = (p.tr < p.er) ? p.tr : p.er;
        ob  = (p.tb > p.eb) ? p.tb : p.eb;
        ot  = (p.tt < p.et) ? p.tt : p.et;
        piece_buf.delete();
        // with a non-empty overlap that is not the whole target, some piece
        // always survives; erased stays as the fallback if none does
        lone = ST_ERASED;
        if (orr <= ol || ot <= ob)
            lone = ST_UNTOUCHED;
        else if (ol == p.tl && orr == p.tr && ob == p.tb && ot == p.tt)
            lone = ST_ERASED;
        else if (p.el <= p.tl && p.er > p.tl)
        begin
            // eraser bites the left side: right, top, bottom
            if (p.tr > p.er) add_piece(orr, p.tr, p.tb, p.tt);
            if (p.tt > p.et) add_piece(p.tl, orr, ot, p.tt);
            if (p.tb < p.eb) add_piece(p.tl, orr, p.tb, ob);
        end
        else if (p.er >= p.tr && p.el < p.tr)
        begin
            // right side: left, top, bottom
            if (p.tl < p.el) add_piece(p.tl, ol, p.tb, p.tt);
            if (p.tt > p.et) add_piece(ol, p.tr, ot, p.tt);
            if (p.tb < p.eb) add_piece(ol, p.tr, p.tb, ob);
        end
        else if (p.eb <= p.tb && p.et > p.tb)
        begin
            // bottom side: top, left, right
            if (p.tt > p.et) add_piece(p.tl, p.tr, ot, p.tt);
            if (p.tl < p.el) add_piece(p.tl, ol, p.tb, ot);
            if (p.tr > p.er) add_piece(orr, p.tr, p.tb, ot);
        end
        else if (p.et >= p.tt && p.eb < p.tt)
        begin
            // top side: bottom, left, right
            if (p.tb < p.eb) add_piece(p.tl, p.tr, p.tb, ob);
            if (p.tl < p.el) add_piece(p.tl, ol, ob, p.tt);
            if (p.tr > p.er) add_piece(orr, p.tr, ob, p.tt);
        end
        else
        begin
            // eraser strictly inside: left, right, top, bottom
            add_piece(p.tl, p.el, p.tb, p.tt);
            add_piece(p.er, p.tr, p.tb, p.tt);
            add_piece(p.el, p.er, p.et, p.tt);
            add_piece(p.el, p.er, p.tb, p.eb);
        end

        if (piece_buf.size() == 0)
        begin
            bt.status = lone;
            bt.l = '0;
            bt.r = '0;
            bt.b = '0;
            bt.t = '0;
            bt.last = 1'b1;
            beat_q.push_back(bt);
        end
        else
        begin
            piece_buf[piece_buf.size()-1].last = 1'b1;
            foreach (piece_buf[i])
                beat_q.push_back(piece_buf[i]);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int rnd(int lo, int hi);
        return int'($urandom_range(hi, lo));
    endfunction

    function automatic int clamp16(int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic rect_pair_t mk_pair(int tl, int tr, int tb, int tt,
                                           int el, int er, int eb, int et);
        rect_pair_t p;
        p.tl = coord_t'(tl);
        p.tr = coord_t'(tr);
        p.tb = coord_t'(tb);
        p.tt = coord_t'(tt);
        p.el = coord_t'(el);
        p.er = coord_t'(er);
        p.eb = coord_t'(eb);
        p.et = coord_t'(et);
        return p;
    endfunction

    // Target span: mostly short, now and then up to the full range.
    function automatic void pick_span(output int lo, output int hi);
        int base, len;
        base = rnd(0, 65535) - 32768;
        len  = (rnd(0, 9) == 0) ? rnd(1, 65535) : rnd(1, 40);
        hi   = clamp16(base + len);
        lo   = base;
        if (hi <= lo)
            lo = hi - 1;
    endfunction

    // Eraser edge relative to a target span: outside, on an edge, between, or anywhere.
    function automatic int pick_cut(int lo, int hi);
        case (rnd(0, 6))
            0: return clamp16(lo - rnd(1, 30));
            1: return lo;
            2, 3: return (hi - lo > 1) ? lo + 1 + rnd(0, hi - lo - 2) : lo;
            4: return hi;
            5: return clamp16(hi + rnd(1, 30));
            default: return rnd(0, 65535) - 32768;
        endcase
    endfunction

    function automatic rect_pair_t random_pair();
        rect_pair_t p;
        int tl, tr, tb, tt, el, er, eb, et, tmp, kind;
        kind = rnd(0, 99);
        if (kind < 10)
        begin
            // raw noise: every bit of every field free
            p = mk_pair(rnd(0, 65535), rnd(0, 65535), rnd(0, 65535), rnd(0, 65535),
                        rnd(0, 65535), rnd(0, 65535), rnd(0, 65535), rnd(0, 65535));
            return p;
        end
        pick_span(tl, tr);
        pick_span(tb, tt);
        el = pick_cut(tl, tr);
        er = pick_cut(tl, tr);
        eb = pick_cut(tb, tt);
        et = pick_cut(tb, tt);
        if (el > er && rnd(0, 9) != 0)
        begin
            tmp = el; el = er; er = tmp;
        end
        if (eb > et && rnd(0, 9) != 0)
        begin
            tmp = eb; eb = et; et = tmp;
        end
        if (kind < 20)
        begin
            // broken: invert one target axis
            if (rnd(0, 1) == 0)
            begin
                tmp = tl; tl = tr; tr = tmp;
            end
            else
            begin
                tmp = tb; tb = tt; tt = tmp;
            end
        end
        return mk_pair(tl, tr, tb, tt, el, er, eb, et);
    endfunction

    // Quiet window: neither side idles while these items go in.
    function automatic bit side_idles();
        if (items_in >= 220 && items_in < 320)
            return 1'b0;
        return rnd(0, 99) < IDLE_PCT;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                subtract_rect(offer);
                items_in++;
            end
            // a stalled beat stays on the ports unchanged
            if (!(push && full))
            begin
                if (rect_q.size() > 0 && (hold || !side_idles()))
                begin
                    offer <= rect_q.pop_front();
                    push  <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : mon
        beat_t w;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (beat_q.size() == 0)
                begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                        $display("ERROR: unexpected result beat: status %0d piece %0d %0d %0d %0d last %0b",
                                 status, piece_left, piece_right, piece_bottom, piece_top, last);
                end
                else
                begin
                    w = beat_q.pop_front();
                    if (status !== w.status || piece_left !== w.l || piece_right !== w.r ||
                        piece_bottom !== w.b || piece_top !== w.t || last !== w.last)
                    begin
                        n_err++;
                        if (n_err <= MAX_SHOWN)
                            $display("ERROR: beat %0d: expected st %0d l %0d r %0d b %0d t %0d last %0b, got st %0d l %0d r %0d b %0d t %0d last %0b",
                                     beats_out, w.status, w.l, w.r, w.b, w.t, w.last,
                                     status, piece_left, piece_right, piece_bottom, piece_top,
                                     last);
                    end
                    case (w.status)
                        ST_UNTOUCHED: n_untouched++;
                        ST_ERASED:    n_erased++;
                        default:      n_pieces++;
                    endcase
                end
                beats_out++;
            end
            pop <= !hold && !side_idles();
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cnt <= 0;
            else if (stall_cnt + 1 >= STALL_LIMIT)
            begin
                $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    // ---------------------------------------------------------------- back pressure

    // Receiver stops popping for a long stretch while the sender keeps
    // offering, so the job queue fills and full holds the input off.
    initial
    begin
        do
            @(negedge clk);
        while (items_in < 120);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        // untouched: apart, touching in x, touching in y
        rect_q.push_back(mk_pair(-10, 10, -10, 10, 20, 30, -5, 5));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, 10, 20, -5, 5));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -5, 5, 10, 20));
        // inverted target, inverted eraser
        rect_q.push_back(mk_pair(10, -10, -10, 10, -5, 5, -5, 5));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, 5, -5, -5, 5));
        // fully erased: covering and identical
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -20, 20, -20, 20));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -10, 10, -10, 10));
        // one of each class
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -20, 0, -5, 5));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, 0, 20, -5, 5));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -5, 5, -20, 0));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -5, 5, 0, 20));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -5, 5, -5, 5));
        // bands, corner, full-height bite
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -20, 20, -2, 2));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -2, 2, -20, 20));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, 5, 20, 5, 20));
        rect_q.push_back(mk_pair(-10, 10, -10, 10, -20, 0, -20, 20));
        // extremes of the coordinate range
        rect_q.push_back(mk_pair(-32768, 32767, -32768, 32767, -1, 1, -1, 1));
        rect_q.push_back(mk_pair(-32768, 32767, -32768, 32767,
                                 -32768, 32767, -32768, 32767));
        rect_q.push_back(mk_pair(-32768, 32767, -32768, 32767, -32768, 0, -32768, 32767));
        rect_q.push_back(mk_pair(-32768, 32767, -32768, 32767, 0, 32767, -32768, 0));
        rect_q.push_back(mk_pair(-32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768));
        rect_q.push_back(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        rect_q.push_back(mk_pair(-32768, 32767, -32768, 32767,
                                 -32767, 32766, -32767, 32766));

        repeat (N_RANDOM)
            rect_q.push_back(random_pair());
        n_items = rect_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (items_in < n_items);
        while (beat_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Pushed %0d rectangle pairs (directed edges, classes, extremes, noise).",
                 items_in);
        $display("Checked %0d result beats: %0d untouched, %0d erased, %0d pieces; %0d errors.",
                 beats_out, n_untouched, n_erased, n_pieces, n_err);
        if (n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
